/* rtl/qlg_pkg.sv */
// qlg_pkg: shared types, field widths, register indexes and reset values
// for the quality level governor. No dependencies.
package qlg_pkg;

    // Field widths
    localparam int FRAME_W   = 20;
    localparam int ELAPSED_W = 20;
    localparam int TARGET_W  = 20;
    localparam int HYST_W    = 15;
    localparam int TIMER_W   = 24;
    localparam int LEVEL_W   = 3;

    // Port widths
    localparam int IN_TDATA_W  = 40;  // frame_time_us + elapsed_us
    localparam int OUT_TDATA_W = 8;   // 6 bits of result padded to a byte
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 24;

    // Counter width default
    localparam int COUNT_WIDTH_DEF = 16;

    // Level range
    localparam logic [LEVEL_W-1:0] LEVEL_BEST   = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_LOWEST = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HYST   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 8'd3;

    // Configuration reset values
    localparam logic                RST_ENABLE = 1'b1;
    localparam logic [TARGET_W-1:0] RST_TARGET = 20'd8333;
    localparam logic [HYST_W-1:0]   RST_HYST   = 15'd10;
    localparam logic [TIMER_W-1:0]  RST_DELAY  = 24'd1000000;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    typedef struct packed {
        logic                enable;
        logic [TARGET_W-1:0] target_frame_us;
        logic [HYST_W-1:0]   hysteresis_frames;
        logic [TIMER_W-1:0]  change_delay_us;
    } cfg_t;

    typedef struct packed {
        logic slow;
        logic fast;
    } class_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] quality_level;
        logic               level_changed;
        logic               running_slow;
        logic               running_fast;
    } res_t;

endpackage

/* rtl/qlg_classify.sv */
// qlg_classify: sorts one frame time into slow (> 1.1 x target) or fast
// (< 0.8 x target) with exact constant shift-add products. Uses qlg_pkg.
module qlg_classify (
    input  logic [qlg_pkg::FRAME_W-1:0]  frame_time_us,
    input  logic [qlg_pkg::TARGET_W-1:0] target_frame_us,
    output qlg_pkg::class_t              cls
);
    import qlg_pkg::*;

    localparam int PROD_W = 24;

    logic [PROD_W-1:0] f10;
    logic [PROD_W-1:0] t11;
    logic [PROD_W-1:0] t8;

    // 10*frame, 11*target and 8*target all fit in 24 bits
    assign f10 = {1'b0, frame_time_us, 3'b0} + {3'b0, frame_time_us, 1'b0};
    assign t11 = {1'b0, target_frame_us, 3'b0} + {3'b0, target_frame_us, 1'b0}
               + {4'b0, target_frame_us};
    assign t8  = {1'b0, target_frame_us, 3'b0};

    always_comb begin
        cls.slow = (f10 > t11);
        cls.fast = !cls.slow && (f10 < t8);
    end

endmodule

/* rtl/qlg_state.sv */
// qlg_state: level, run counters and change timer; computes one result per
// processed frame. Uses qlg_pkg.
module qlg_state #(
    parameter int COUNT_WIDTH = qlg_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  qlg_pkg::cfg_t                 cfg,
    input  qlg_pkg::class_t               cls,
    input  logic [qlg_pkg::ELAPSED_W-1:0] elapsed_us,
    output qlg_pkg::res_t                 res
);
    import qlg_pkg::*;

    localparam int CMP_W = ((COUNT_WIDTH > HYST_W + 1) ? COUNT_WIDTH : HYST_W + 1) + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [LEVEL_W-1:0]     level_reg,  level_next;
    logic [COUNT_WIDTH-1:0] slow_reg,   slow_next;
    logic [COUNT_WIDTH-1:0] fast_reg,   fast_next;
    logic [TIMER_W-1:0]     timer_reg,  timer_next;

    logic [TIMER_W:0]       t_sum;
    logic [TIMER_W-1:0]     t_sat;
    logic                   delay_ok;
    logic [COUNT_WIDTH-1:0] slow_up, fast_up, slow_cnt, fast_cnt;
    logic [CMP_W-1:0]       slow_ext, fast_ext, hyst_ext, hyst2_ext;
    logic                   slow_trip, fast_trip;
    logic                   changed;

    // Saturating timer, runs whether enabled or not
    assign t_sum    = {1'b0, timer_reg} + {{(TIMER_W + 1 - ELAPSED_W){1'b0}}, elapsed_us};
    assign t_sat    = t_sum[TIMER_W] ? TIMER_MAX : t_sum[TIMER_W-1:0];
    assign delay_ok = (t_sat >= cfg.change_delay_us);

    // Saturating run counters
    assign slow_up = (slow_reg == COUNT_MAX) ? slow_reg : slow_reg + COUNT_WIDTH'(1);
    assign fast_up = (fast_reg == COUNT_MAX) ? fast_reg : fast_reg + COUNT_WIDTH'(1);
    assign slow_cnt = cls.slow ? slow_up : '0;
    assign fast_cnt = cls.fast ? fast_up : '0;

    // Threshold compares at a common width
    assign slow_ext  = {{(CMP_W - COUNT_WIDTH){1'b0}}, slow_cnt};
    assign fast_ext  = {{(CMP_W - COUNT_WIDTH){1'b0}}, fast_cnt};
    assign hyst_ext  = {{(CMP_W - HYST_W){1'b0}}, cfg.hysteresis_frames};
    assign hyst2_ext = {{(CMP_W - HYST_W - 1){1'b0}}, cfg.hysteresis_frames, 1'b0};
    assign slow_trip = (slow_ext > hyst_ext);
    assign fast_trip = (fast_ext > hyst2_ext);

    // Level decision
    always_comb begin
        level_next = level_reg;
        slow_next  = slow_reg;
        fast_next  = fast_reg;
        timer_next = t_sat;
        changed    = 1'b0;
        if (cfg.enable) begin
            slow_next = slow_cnt;
            fast_next = fast_cnt;
            priority if (slow_trip) begin
                if (level_reg != LEVEL_LOWEST && delay_ok) begin
                    level_next = level_reg + LEVEL_W'(1);
                    timer_next = '0;
                    slow_next  = '0;
                    changed    = 1'b1;
                end
            end else if (fast_trip) begin
                if (level_reg != LEVEL_BEST && delay_ok) begin
                    level_next = level_reg - LEVEL_W'(1);
                    timer_next = '0;
                    fast_next  = '0;
                    changed    = 1'b1;
                end
            end else begin
                // neither run is long enough: level holds
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= LEVEL_BEST;
            slow_reg  <= '0;
            fast_reg  <= '0;
            timer_reg <= '0;
        end else if (step) begin
            level_reg <= level_next;
            slow_reg  <= slow_next;
            fast_reg  <= fast_next;
            timer_reg <= timer_next;
        end
    end

    always_comb begin
        res.quality_level = level_next;
        res.level_changed = changed;
        res.running_slow  = cfg.enable & cls.slow;
        res.running_fast  = cfg.enable & cls.fast;
    end

endmodule

/* rtl/quality_level_governor.sv */
// Quality level governor: takes one frame-time beat per frame and returns one
// result beat holding the quality level (0 best .. 4 lowest) after that frame.
// A beat passes an input register, combinational compare and counter logic and
// a result register, and a new beat is taken every cycle while m_tready does
// not stall the result; qlg_state updates its state once per beat. Configuration
// writes are taken on every cycle and must only happen while no beat is in
// flight.
// Depends on qlg_pkg, qlg_classify, qlg_state.
module quality_level_governor #(
    parameter int COUNT_WIDTH = qlg_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Frame input: [19:0] frame_time_us, [39:20] elapsed_us
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [qlg_pkg::IN_TDATA_W-1:0]  s_tdata,
    // Result: [2:0] quality_level, [3] level_changed, [4] running_slow,
    // [5] running_fast, [7:6] zero
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [qlg_pkg::OUT_TDATA_W-1:0] m_tdata,
    // Configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [qlg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qlg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import qlg_pkg::*;

    cfg_t                 cfg_reg;
    logic                 in_vld_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic                 out_vld_reg;
    res_t                 out_reg;
    logic                 adv;
    class_t               cls;
    res_t                 res;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable            <= RST_ENABLE;
            cfg_reg.target_frame_us   <= RST_TARGET;
            cfg_reg.hysteresis_frames <= RST_HYST;
            cfg_reg.change_delay_us   <= RST_DELAY;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ENABLE: cfg_reg.enable            <= cfg_data[0];
                REG_TARGET: cfg_reg.target_frame_us   <= cfg_data[TARGET_W-1:0];
                REG_HYST:   cfg_reg.hysteresis_frames <= cfg_data[HYST_W-1:0];
                REG_DELAY:  cfg_reg.change_delay_us   <= cfg_data[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow: input stage moves on when the result slot is free
    assign adv      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            frame_reg   <= s_tdata[FRAME_W-1:0];
            elapsed_reg <= s_tdata[FRAME_W +: ELAPSED_W];
        end
    end

    qlg_classify u_classify (
        .frame_time_us   (frame_reg),
        .target_frame_us (cfg_reg.target_frame_us),
        .cls             (cls)
    );

    qlg_state #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (adv),
        .cfg        (cfg_reg),
        .cls        (cls),
        .elapsed_us (elapsed_reg),
        .res        (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, out_reg.running_fast, out_reg.running_slow,
                       out_reg.level_changed, out_reg.quality_level};

endmodule

/* rtl/qlg_checker.sv */
// qlg_checker: port-level checks on the quality level governor result
// stream, bound to the top level. Uses qlg_pkg.
module qlg_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [qlg_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import qlg_pkg::*;

    // A stalled result beat holds its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // Level stays within range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= LEVEL_LOWEST))
        else $error("quality level out of range");

    // A frame is never both slow and fast
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[4] && m_tdata[5]))
        else $error("frame flagged slow and fast");

    // A slow-driven change cannot land on best quality
    a_slow_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] && m_tdata[4] |-> (m_tdata[2:0] != LEVEL_BEST))
        else $error("slow change ended at best level");

    // A fast-driven change cannot land on lowest quality
    a_fast_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] && m_tdata[5] |-> (m_tdata[2:0] != LEVEL_LOWEST))
        else $error("fast change ended at lowest level");

endmodule

bind quality_level_governor qlg_checker u_qlg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
